[hw/rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LRU block cache tag lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

  localparam int unsigned DEV_W  = 8;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OUTC_W = 2;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_HIT   = 2'd0,
    OUTC_FILL  = 2'd1,
    OUTC_EVICT = 2'd2
  } outcome_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic compare;
    logic update;
    logic hit_any;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/lbc_if.sv]
// ----------------------------------------------------------------------------
// lbc_req_if / lbc_rsp_if
// Valid/ready channels for lookup requests and lookup results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lbc_req_if;
  logic                     valid;
  logic                     ready;
  logic [lbc_pkg::DEV_W-1:0] device_id;
  logic [lbc_pkg::BLK_W-1:0] block_address;

  modport source (output valid, output device_id, output block_address, input ready);
  modport sink   (input valid, input device_id, input block_address, output ready);
endinterface

interface lbc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lbc_pkg::OUTC_W-1:0] outcome;
  logic [lbc_pkg::SLOT_W-1:0] slot;
  logic [lbc_pkg::CNT_W-1:0]  hit_total;
  logic [lbc_pkg::CNT_W-1:0]  miss_total;
  logic [lbc_pkg::CNT_W-1:0]  fill_total;

  modport source (output valid, output outcome, output slot, output hit_total,
                  output miss_total, output fill_total, input ready);
  modport sink   (input valid, input outcome, input slot, input hit_total,
                  input miss_total, input fill_total, output ready);
endinterface

`default_nettype wire

[hw/rtl/lru_block_cache_lookup.sv]
// ----------------------------------------------------------------------------
// lru_block_cache_lookup
// Fully associative tag lookup with move-to-front LRU ordering, built as a
// chain of recency cells.
// ----------------------------------------------------------------------------
//  channel  dir  item contents
//  req_i    in   device_id, block_address
//  rsp_o    out  outcome, slot, hit_total, miss_total, fill_total
//
//  the accept edge registers the tag compare in every cell, and the update
//  then shifts the cell chain and loads the result register.
//  the update waits while a previous result in rsp_o has not been taken.
//  no new item is taken until the update of the current one is done.
//  reset empties every cell, sets slot i mod 16 in cell i and zeroes counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache_lookup #(
  parameter int unsigned WAYS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbc_req_if.sink   req_i,
  lbc_rsp_if.source rsp_o
);

  lbc_pkg::state_e           state_q, state_d;
  lbc_pkg::cell_ctl_t        ctl;
  logic                      in_fire;
  logic                      advance;
  logic                      hit_any;
  lbc_pkg::outcome_e         outcome;

  logic [lbc_pkg::DEV_W-1:0]  dev_q;
  logic [lbc_pkg::BLK_W-1:0]  blk_q;
  logic [lbc_pkg::CNT_W-1:0]  hit_cnt_q, hit_cnt_d;
  logic [lbc_pkg::CNT_W-1:0]  miss_cnt_q, miss_cnt_d;
  logic [lbc_pkg::CNT_W-1:0]  fill_cnt_q, fill_cnt_d;

  logic                      rsp_valid_q;
  lbc_pkg::outcome_e         rsp_outcome_q;
  logic [lbc_pkg::SLOT_W-1:0] rsp_slot_q;

  logic                      valid_w    [WAYS];
  logic                      hit_w      [WAYS];
  logic [lbc_pkg::DEV_W-1:0]  dev_w      [WAYS];
  logic [lbc_pkg::BLK_W-1:0]  blk_w      [WAYS];
  logic [lbc_pkg::SLOT_W-1:0] slot_w     [WAYS];
  logic [lbc_pkg::SLOT_W-1:0] sel_slot_w [WAYS];
  logic                      suffix_w   [WAYS+1];
  logic [WAYS-1:0]           hit_vec;
  logic [WAYS-1:0]           valid_vec;
  logic [lbc_pkg::SLOT_W-1:0] front_slot;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == lbc_pkg::ST_IDLE);

  always_comb begin
    front_slot = '0;
    for (int i = 0; i < WAYS; i++) begin
      front_slot = front_slot | sel_slot_w[i];
      hit_vec[i]   = hit_w[i];
      valid_vec[i] = valid_w[i];
    end
  end

  assign hit_any = suffix_w[0];

  // sequencer
  always_comb begin
    state_d = state_q;
    advance = 1'b0;
    case (state_q)
      lbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = lbc_pkg::ST_UPDATE;
        end
      end
      lbc_pkg::ST_UPDATE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          advance = 1'b1;
          state_d = lbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl.compare = in_fire;
    ctl.update  = advance;
    ctl.hit_any = hit_any;
  end

  always_comb begin
    if (hit_any) begin
      outcome = lbc_pkg::OUTC_HIT;
    end else if (valid_w[WAYS-1]) begin
      outcome = lbc_pkg::OUTC_EVICT;
    end else begin
      outcome = lbc_pkg::OUTC_FILL;
    end
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    fill_cnt_d = fill_cnt_q;
    case (outcome)
      lbc_pkg::OUTC_HIT:   hit_cnt_d  = hit_cnt_q + 1'b1;
      lbc_pkg::OUTC_FILL:  fill_cnt_d = fill_cnt_q + 1'b1;
      lbc_pkg::OUTC_EVICT: miss_cnt_d = miss_cnt_q + 1'b1;
      default:             hit_cnt_d  = hit_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dev_q <= req_i.device_id;
      blk_q <= req_i.block_address;
    end
    if (advance) begin
      rsp_outcome_q <= outcome;
      rsp_slot_q    <= front_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fill_cnt_q  <= '0;
    end else begin
      if (advance) begin
        rsp_valid_q <= 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        fill_cnt_q  <= fill_cnt_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.outcome    = rsp_outcome_q;
  assign rsp_o.slot       = rsp_slot_q;
  assign rsp_o.hit_total  = hit_cnt_q;
  assign rsp_o.miss_total = miss_cnt_q;
  assign rsp_o.fill_total = fill_cnt_q;

  assign suffix_w[WAYS] = 1'b0;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    logic                      prev_valid;
    logic [lbc_pkg::DEV_W-1:0]  prev_dev;
    logic [lbc_pkg::BLK_W-1:0]  prev_blk;
    logic [lbc_pkg::SLOT_W-1:0] prev_slot;

    if (g == 0) begin : g_front
      // the head always receives the requested tag with the moving slot
      assign prev_valid = 1'b1;
      assign prev_dev   = dev_q;
      assign prev_blk   = blk_q;
      assign prev_slot  = front_slot;
    end else begin : g_link
      assign prev_valid = valid_w[g-1];
      assign prev_dev   = dev_w[g-1];
      assign prev_blk   = blk_w[g-1];
      assign prev_slot  = slot_w[g-1];
    end

    // the compare runs on the accept edge, against the item on the channel
    lbc_cell #(
      .SLOT_INIT (lbc_pkg::SLOT_W'(g)),
      .IS_LAST   (g == WAYS - 1)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .req_device_i  (req_i.device_id),
      .req_block_i   (req_i.block_address),
      .prev_valid_i  (prev_valid),
      .prev_device_i (prev_dev),
      .prev_block_i  (prev_blk),
      .prev_slot_i   (prev_slot),
      .suffix_i      (suffix_w[g+1]),
      .suffix_o      (suffix_w[g]),
      .hit_o         (hit_w[g]),
      .valid_o       (valid_w[g]),
      .device_o      (dev_w[g]),
      .block_o       (blk_w[g]),
      .slot_o        (slot_w[g]),
      .sel_slot_o    (sel_slot_w[g])
    );
  end

  // tags are unique, so at most one cell can hit
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbc_pkg::ST_UPDATE) |-> $onehot0(hit_vec))
    else $error("more than one cell hit");

  // used entries stay ahead of free ones
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + {{(WAYS-1){1'b0}}, 1'b1})) == '0)
    else $error("free entry ahead of a used entry");

  // after an update the head holds the requested tag
  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (valid_w[0] && dev_w[0] == $past(dev_q) && blk_w[0] == $past(blk_q)))
    else $error("head entry not installed after update");

  // exactly one counter moves per item
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((hit_cnt_q != $past(hit_cnt_q)) + (miss_cnt_q != $past(miss_cnt_q))
                 + (fill_cnt_q != $past(fill_cnt_q))) == 2'd1)
    else $error("counter update not exclusive");

endmodule

`default_nettype wire

[hw/rtl/lbc_cell.sv]
// ----------------------------------------------------------------------------
// lbc_cell
// One recency position: holds a tag entry, compares it with the request and
// takes the entry of its upper neighbor when the list moves down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_cell #(
  parameter logic [lbc_pkg::SLOT_W-1:0] SLOT_INIT = '0,
  parameter bit                         IS_LAST   = 1'b0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lbc_pkg::cell_ctl_t        ctl_i,
  input  wire logic [lbc_pkg::DEV_W-1:0]  req_device_i,
  input  wire logic [lbc_pkg::BLK_W-1:0]  req_block_i,
  input  wire logic                      prev_valid_i,
  input  wire logic [lbc_pkg::DEV_W-1:0]  prev_device_i,
  input  wire logic [lbc_pkg::BLK_W-1:0]  prev_block_i,
  input  wire logic [lbc_pkg::SLOT_W-1:0] prev_slot_i,
  input  wire logic                      suffix_i,
  output logic                           suffix_o,
  output logic                           hit_o,
  output logic                           valid_o,
  output logic [lbc_pkg::DEV_W-1:0]       device_o,
  output logic [lbc_pkg::BLK_W-1:0]       block_o,
  output logic [lbc_pkg::SLOT_W-1:0]      slot_o,
  output logic [lbc_pkg::SLOT_W-1:0]      sel_slot_o
);

  logic                      valid_q;
  logic [lbc_pkg::DEV_W-1:0]  device_q;
  logic [lbc_pkg::BLK_W-1:0]  block_q;
  logic [lbc_pkg::SLOT_W-1:0] slot_q;
  logic                      hit_q;
  logic                      match;
  logic                      take;
  logic                      sel;

  always_comb begin
    match    = valid_q && (device_q == req_device_i) && (block_q == req_block_i);
    // a hit here or further down means this position moves down by one
    suffix_o = hit_q | suffix_i;
    take     = ctl_i.hit_any ? suffix_o : prev_valid_i;
    // the moving entry: the hit, else the first free, else the last position
    sel      = ctl_i.hit_any ? hit_q : (prev_valid_i && (!valid_q || IS_LAST));
    sel_slot_o = sel ? slot_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      device_q <= '0;
      block_q  <= '0;
      slot_q   <= SLOT_INIT;
      hit_q    <= 1'b0;
    end else begin
      if (ctl_i.compare) begin
        hit_q <= match;
      end
      if (ctl_i.update && take) begin
        valid_q  <= prev_valid_i;
        device_q <= prev_device_i;
        block_q  <= prev_block_i;
        slot_q   <= prev_slot_i;
      end
    end
  end

  assign hit_o    = hit_q;
  assign valid_o  = valid_q;
  assign device_o = device_q;
  assign block_o  = block_q;
  assign slot_o   = slot_q;

endmodule

`default_nettype wire
